/* design/alids_pkg.sv */
package alids_pkg;

  localparam int POS_W   = 11;
  localparam int LANES   = 8;
  localparam int LANE_W  = 3;
  localparam int AGE_W   = 8;
  localparam int POS_IN_W = 8;
  localparam int FOUND_W = 7;
  localparam int ENTRY_W = 8;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_SEARCH = 2'd1,
    OP_DELETE = 2'd2,
    OP_INSERT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_FULL     = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_BADPOS   = 3'd3,
    STS_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CK_HOLD,
    CK_INSERT,
    CK_DELETE,
    CK_SEARCH
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t       kind;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] cnt;
  } cell_cmd_t;

  typedef struct packed {
    logic               done;
    logic               hit;
    logic [FOUND_W-1:0] idx;
  } scan_res_t;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_t;

endpackage

/* design/alids_cell.sv */
module alids_cell #(
  parameter int NAME_BITS = 48,
  parameter int IDX       = 0
) (
  input  logic                           clk,
  input  alids_pkg::cell_cmd_t           cmd,
  input  logic [NAME_BITS-1:0]           key,
  input  logic [alids_pkg::AGE_W-1:0]    age,
  input  logic [NAME_BITS-1:0]           prev_name,
  input  logic [alids_pkg::AGE_W-1:0]    prev_age,
  input  logic [NAME_BITS-1:0]           next_name,
  input  logic [alids_pkg::AGE_W-1:0]    next_age,
  output logic [NAME_BITS-1:0]           name_q,
  output logic [alids_pkg::AGE_W-1:0]    age_q,
  output logic                           match_q
);

  localparam logic [alids_pkg::POS_W-1:0] IDX_P = alids_pkg::POS_W'(IDX);

  logic [NAME_BITS-1:0]        name_r, name_nxt;
  logic [alids_pkg::AGE_W-1:0] age_r, age_nxt;
  logic                        match_r, match_nxt;

  always_comb begin
    name_nxt  = name_r;
    age_nxt   = age_r;
    match_nxt = match_r;
    unique case (cmd.kind)
      alids_pkg::CK_INSERT: begin
        if (IDX_P > cmd.pos) begin
          name_nxt = prev_name;
          age_nxt  = prev_age;
        end else if (IDX_P == cmd.pos) begin
          name_nxt = key;
          age_nxt  = age;
        end
      end
      alids_pkg::CK_DELETE: begin
        if (IDX_P >= cmd.pos) begin
          name_nxt = next_name;
          age_nxt  = next_age;
        end
      end
      alids_pkg::CK_SEARCH: begin
        match_nxt = (IDX_P < cmd.cnt) && (name_r == key) && (age_r == age);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    name_r  <= name_nxt;
    age_r   <= age_nxt;
    match_r <= match_nxt;
  end

  assign name_q  = name_r;
  assign age_q   = age_r;
  assign match_q = match_r;

endmodule

/* design/alids_scan.sv */
module alids_scan #(
  parameter int CAPACITY = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  run,
  input  logic [CAPACITY-1:0]   match,
  output alids_pkg::scan_res_t  res
);

  localparam int NG  = (CAPACITY + alids_pkg::LANES - 1) / alids_pkg::LANES;
  localparam int PAD = NG * alids_pkg::LANES;
  localparam int GW  = (NG > 1) ? $clog2(NG) : 1;

  logic [GW-1:0]                   grp_r, grp_nxt;
  logic [PAD-1:0]                  match_pad;
  logic [alids_pkg::LANES-1:0]     slice;
  logic [alids_pkg::LANE_W-1:0]    enc;
  logic                            last;

  assign match_pad = PAD'(match);
  assign slice     = match_pad[int'(grp_r) * alids_pkg::LANES +: alids_pkg::LANES];
  assign last      = (grp_r == GW'(NG - 1));

  always_comb begin
    enc = '0;
    for (int i = alids_pkg::LANES - 1; i >= 0; i--) begin
      if (slice[i]) begin
        enc = alids_pkg::LANE_W'(i);
      end
    end
  end

  always_comb begin
    res.hit  = |slice;
    res.done = run && (res.hit || last);
    res.idx  = alids_pkg::FOUND_W'(int'(grp_r) * alids_pkg::LANES + int'(enc));
  end

  always_comb begin
    grp_nxt = grp_r;
    priority if (start) begin
      grp_nxt = '0;
    end else if (run && !res.done) begin
      grp_nxt = grp_r + GW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r <= '0;
    end else begin
      grp_r <= grp_nxt;
    end
  end

endmodule

/* design/array_list_insert_delete_search.sv */
// Ordered list of up to CAPACITY records (name key, age) held in a row of cells.
// Input channel in_*: tuser carries the opcode (append, search, delete, insert);
// tdata carries name_key, age and position. Output channel out_*: one item per
// request, tuser carries the status, tdata the found index and the new count.
// Append, delete and insert shift or load the cells at and above the position;
// the result appears on out_tvalid the cycle after acceptance. A search latches
// a match bit in every cell in the accept cycle, then scans the match bits eight
// cells per cycle, lowest position first, and loads the output register when it
// ends. A search on an empty list answers the cycle after acceptance.
// One request is in flight at a time; in_tready is high while no search scan
// runs and the output register is empty or being taken in that cycle.
// When the receiver stalls, the result holds on out_* and in_tready stays low.
// Reset (rst_n low, synchronous) empties the list and drops any pending result;
// cell contents are not cleared and are never read beyond the count.
module array_list_insert_delete_search #(
  parameter int CAPACITY  = 128,
  parameter int NAME_BITS = 48
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // name_key, age, position
  input  logic [((NAME_BITS + 16 + 7) / 8) * 8-1:0] in_tdata,
  // opcode
  input  logic [1:0]                               in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // found_index, entry_count
  output logic [15:0]                              out_tdata,
  // status
  output logic [2:0]                               out_tuser
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [NAME_BITS-1:0]                 key;
  logic [alids_pkg::AGE_W-1:0]          age;
  logic [alids_pkg::POS_W-1:0]          pos_ext, cnt_ext;
  alids_pkg::op_t                       op;

  logic [NAME_BITS-1:0]                 name_q [CAPACITY];
  logic [alids_pkg::AGE_W-1:0]          age_q  [CAPACITY];
  logic [CAPACITY-1:0]                  match;

  alids_pkg::state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]                     cnt_r, cnt_nxt;
  logic                                 out_valid_r;
  alids_pkg::status_t                   status_r;
  logic [alids_pkg::FOUND_W-1:0]        idx_r;
  logic [alids_pkg::ENTRY_W-1:0]        entry_r;

  alids_pkg::cell_cmd_t                 cmd;
  alids_pkg::scan_res_t                 scan;
  logic                                 in_acc, scan_start, res_load;
  alids_pkg::status_t                   res_status;
  logic [alids_pkg::FOUND_W-1:0]        res_idx;

  assign key     = in_tdata[NAME_BITS-1:0];
  assign age     = in_tdata[NAME_BITS +: alids_pkg::AGE_W];
  assign pos_ext = alids_pkg::POS_W'(in_tdata[NAME_BITS + alids_pkg::AGE_W +:
                                              alids_pkg::POS_IN_W]);
  assign cnt_ext = alids_pkg::POS_W'(cnt_r);
  assign op      = alids_pkg::op_t'(in_tuser);
  assign in_acc  = in_tvalid && in_tready;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [NAME_BITS-1:0]        pn, nn;
    logic [alids_pkg::AGE_W-1:0] pa, na;
    if (i == 0) begin : g_first
      assign pn = name_q[i];
      assign pa = age_q[i];
    end else begin : g_mid_lo
      assign pn = name_q[i-1];
      assign pa = age_q[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign nn = name_q[i];
      assign na = age_q[i];
    end else begin : g_mid_hi
      assign nn = name_q[i+1];
      assign na = age_q[i+1];
    end
    alids_cell #(
      .NAME_BITS (NAME_BITS),
      .IDX       (i)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .key       (key),
      .age       (age),
      .prev_name (pn),
      .prev_age  (pa),
      .next_name (nn),
      .next_age  (na),
      .name_q    (name_q[i]),
      .age_q     (age_q[i]),
      .match_q   (match[i])
    );
  end

  alids_scan #(
    .CAPACITY (CAPACITY)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (scan_start),
    .run   (state_r == alids_pkg::S_SCAN),
    .match (match),
    .res   (scan)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      alids_pkg::S_IDLE: begin
        if (scan_start) begin
          state_nxt = alids_pkg::S_SCAN;
        end
      end
      alids_pkg::S_SCAN: begin
        if (scan.done) begin
          state_nxt = alids_pkg::S_IDLE;
        end
      end
      default: state_nxt = alids_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == alids_pkg::S_IDLE) && (!out_valid_r || out_tready);
    cmd.kind   = alids_pkg::CK_HOLD;
    cmd.pos    = pos_ext;
    cmd.cnt    = cnt_ext;
    cnt_nxt    = cnt_r;
    scan_start = 1'b0;
    res_load   = 1'b0;
    res_status = alids_pkg::STS_OK;
    res_idx    = '0;
    if (in_acc) begin
      res_load = 1'b1;
      unique case (op)
        alids_pkg::OP_APPEND: begin
          if (cnt_r >= CNT_W'(CAPACITY)) begin
            res_status = alids_pkg::STS_FULL;
          end else begin
            cmd.kind = alids_pkg::CK_INSERT;
            cmd.pos  = cnt_ext;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        alids_pkg::OP_SEARCH: begin
          if (cnt_r == '0) begin
            res_status = alids_pkg::STS_EMPTY;
          end else begin
            cmd.kind   = alids_pkg::CK_SEARCH;
            scan_start = 1'b1;
            res_load   = 1'b0;
          end
        end
        alids_pkg::OP_DELETE: begin
          if (cnt_r == '0) begin
            res_status = alids_pkg::STS_EMPTY;
          end else if (pos_ext >= cnt_ext) begin
            res_status = alids_pkg::STS_BADPOS;
          end else begin
            cmd.kind = alids_pkg::CK_DELETE;
            cnt_nxt  = cnt_r - CNT_W'(1);
          end
        end
        alids_pkg::OP_INSERT: begin
          if (cnt_r >= CNT_W'(CAPACITY)) begin
            res_status = alids_pkg::STS_FULL;
          end else if (pos_ext > cnt_ext) begin
            res_status = alids_pkg::STS_BADPOS;
          end else begin
            cmd.kind = alids_pkg::CK_INSERT;
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end else if (scan.done) begin
      res_load   = 1'b1;
      res_status = scan.hit ? alids_pkg::STS_OK : alids_pkg::STS_NOTFOUND;
      res_idx    = scan.hit ? scan.idx : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= alids_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      status_r <= res_status;
      idx_r    <= res_idx;
      entry_r  <= alids_pkg::ENTRY_W'(cnt_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {1'b0, entry_r, idx_r};

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_scan_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == alids_pkg::S_SCAN |-> !out_valid_r)
    else $error("result pending during scan");

  a_imm_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !scan_start |=> out_valid_r)
    else $error("no result after request");

  a_search_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && op == alids_pkg::OP_SEARCH && cnt_r != '0
      |=> state_r == alids_pkg::S_SCAN && !out_valid_r)
    else $error("search did not start a scan");

endmodule
